>>> hw/rtl/bpfa_pkg.sv
// Shared constants, codes and widths for the bitmap page frame allocator.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package bpfa_pkg;

  localparam int unsigned MaxFrames  = 65536;
  localparam int unsigned PageBytes  = 4096;
  localparam int unsigned PAGE_SHIFT = $clog2(PageBytes);

  localparam int unsigned FRAME_W = $clog2(MaxFrames);
  localparam int unsigned COUNT_W = FRAME_W + 1;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned BIT_W   = $clog2(WORD_W);
  localparam int unsigned WIDX_W  = FRAME_W - BIT_W;
  localparam int unsigned SIDX_W  = WIDX_W - BIT_W;
  localparam int unsigned TOP_W   = 2 ** SIDX_W;
  localparam int unsigned NUM_WORDS = 2 ** WIDX_W;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned IN_ADDR_W  = 48;
  localparam int unsigned FADDR_W    = IN_ADDR_W - PAGE_SHIFT;
  localparam int unsigned ADDR_W     = 28;
  localparam int unsigned TOP_ADDR_W = 29;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned TOTAL_W    = 17;

  localparam logic [TOTAL_W-1:0] CountMax = 17'd65536;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic REG_ALLOC_START = 1'b0;
  localparam logic REG_MEMORY_TOP  = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OpInit  = 2'd0,
    OpAlloc = 2'd1,
    OpFree  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    StOk    = 2'd0,
    StOom   = 2'd1,
    StRange = 2'd2
  } status_e;

endpackage

>>> hw/rtl/bpfa_req_if.sv
// Request channel of the page frame allocator: valid/ready with op and address.
// Depends on bpfa_pkg.
`timescale 1ns / 1ps

interface bpfa_req_if;
  logic                            valid;
  logic                            ready;
  logic [bpfa_pkg::OP_W-1:0]       op;
  logic [bpfa_pkg::IN_ADDR_W-1:0]  frame_address;

  modport source (output valid, output op, output frame_address, input ready);
  modport sink   (input valid, input op, input frame_address, output ready);
endinterface

>>> hw/rtl/bpfa_rsp_if.sv
// Response channel of the page frame allocator: valid/ready with result fields.
// Depends on bpfa_pkg.
`timescale 1ns / 1ps

interface bpfa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [bpfa_pkg::ADDR_W-1:0]    result_address;
  logic [bpfa_pkg::STATUS_W-1:0]  status;
  logic [bpfa_pkg::TOTAL_W-1:0]   alloc_total;

  modport source (output valid, output result_address, output status, output alloc_total,
                  input ready);
  modport sink   (input valid, input result_address, input status, input alloc_total,
                  output ready);
endinterface

>>> hw/rtl/bitmap_page_frame_allocator.sv
// Top level of the bitmap page frame allocator: used-bit word memory, summary memory,
// full flags, sequencer and APB register file.
// Depends on bpfa_pkg, bpfa_req_if and bpfa_rsp_if.
//
//   Channel   Dir   Handshake                  Payload
//   req_i     in    valid/ready                op, frame_address
//   rsp_o     out   valid/ready                result_address, status, alloc_total
//   apb       in    psel/penable/pwrite/pready alloc_start (0x0), memory_top (0x4)
//
// One item at a time. Alloc runs summary read, word read, write back and response in
// turn; free runs read, write back and response, and rejected items go straight to the
// response. Init sweeps every used-bit word through the single write port.
// The memories are not cleared by reset; the frame count is zero until the first init.
// A stalled response holds the sequencer in its response state; the next item
// is taken once that response is loaded into the output register.
`timescale 1ns / 1ps

module bitmap_page_frame_allocator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bpfa_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [bpfa_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [bpfa_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  bpfa_req_if.sink                            req_i,
  bpfa_rsp_if.source                          rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ASUM,
    S_AWORD,
    S_FUPD,
    S_RESP
  } state_e;

  typedef logic [bpfa_pkg::WORD_W-1:0]  word_t;
  typedef logic [bpfa_pkg::COUNT_W-1:0] count_t;

  state_e                              state_q;
  logic [bpfa_pkg::ADDR_W-1:0]         alloc_start_q;
  logic [bpfa_pkg::TOP_ADDR_W-1:0]     memory_top_q;
  count_t                              fc_q;
  count_t                              res_q;
  logic [bpfa_pkg::TOTAL_W-1:0]        cnt_q;
  logic [bpfa_pkg::TOP_W-1:0]          top_full_q;
  logic [bpfa_pkg::WIDX_W-1:0]         widx_q;
  word_t                               acc_q;
  logic [bpfa_pkg::FRAME_W-1:0]        fidx_q;
  logic [bpfa_pkg::ADDR_W-1:0]         pend_addr_q;
  bpfa_pkg::status_e                   pend_status_q;
  logic                                rsp_valid_q;
  logic [bpfa_pkg::ADDR_W-1:0]         rsp_addr_q;
  bpfa_pkg::status_e                   rsp_status_q;
  logic [bpfa_pkg::TOTAL_W-1:0]        rsp_total_q;

  word_t                               word_mem [bpfa_pkg::NUM_WORDS];
  word_t                               sum_mem  [bpfa_pkg::TOP_W];
  word_t                               word_rd_q;
  word_t                               sum_rd_q;

  logic                                word_we, word_re, sum_we, sum_re;
  logic [bpfa_pkg::WIDX_W-1:0]         word_waddr, word_raddr;
  logic [bpfa_pkg::SIDX_W-1:0]         sum_waddr, sum_raddr;
  word_t                               word_wdata, sum_wdata;

  bpfa_pkg::op_e                       op_in;
  logic [bpfa_pkg::FADDR_W-1:0]        free_frame;
  logic [bpfa_pkg::FRAME_W-1:0]        free_fidx;
  logic                                in_range;
  logic                                avail;
  logic [bpfa_pkg::SIDX_W-1:0]         s_sel;
  logic [bpfa_pkg::BIT_W-1:0]          w_sel;
  logic [bpfa_pkg::BIT_W-1:0]          b_sel;
  word_t                               init_w;
  word_t                               acc_d;
  word_t                               alloc_word;
  word_t                               alloc_sum;
  logic                                can_out;

  logic [bpfa_pkg::TOP_ADDR_W-bpfa_pkg::PAGE_SHIFT-1:0] fc_raw;
  count_t                              fc_n;
  count_t                              map_bytes;
  logic [31:0]                         res_sum;
  logic [31:0]                         res_raw;
  count_t                              res_n;

  function automatic logic [bpfa_pkg::BIT_W-1:0] low_zero64(input word_t v);
    logic [bpfa_pkg::BIT_W-1:0] idx;
    idx = '0;
    for (int i = bpfa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (!v[i]) idx = bpfa_pkg::BIT_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [bpfa_pkg::SIDX_W-1:0] low_zero_top(
    input logic [bpfa_pkg::TOP_W-1:0] v
  );
    logic [bpfa_pkg::SIDX_W-1:0] idx;
    idx = '0;
    for (int i = bpfa_pkg::TOP_W - 1; i >= 0; i--) begin
      if (!v[i]) idx = bpfa_pkg::SIDX_W'(i);
    end
    return idx;
  endfunction

  function automatic word_t init_word(input logic [bpfa_pkg::WIDX_W-1:0] w,
                                      input count_t fc, input count_t res);
    word_t  v;
    count_t f;
    v = '0;
    for (int i = 0; i < bpfa_pkg::WORD_W; i++) begin
      f    = count_t'({w, bpfa_pkg::BIT_W'(i)});
      v[i] = (f < res) || (f >= fc);
    end
    return v;
  endfunction

  // Configuration registers
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bpfa_pkg::REG_MEMORY_TOP) ?
                  bpfa_pkg::APB_DATA_W'(memory_top_q) :
                  bpfa_pkg::APB_DATA_W'(alloc_start_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_start_q <= 28'd1048576;
      memory_top_q  <= 29'd268435456;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == bpfa_pkg::REG_ALLOC_START) begin
        alloc_start_q <= pwdata[bpfa_pkg::ADDR_W-1:0];
      end else begin
        memory_top_q <= pwdata[bpfa_pkg::TOP_ADDR_W-1:0];
      end
    end
  end

  // Init geometry
  assign fc_raw    = memory_top_q[bpfa_pkg::TOP_ADDR_W-1:bpfa_pkg::PAGE_SHIFT];
  assign fc_n      = (32'(fc_raw) > bpfa_pkg::MaxFrames) ? count_t'(bpfa_pkg::MaxFrames) :
                                                           count_t'(fc_raw);
  assign map_bytes = count_t'((32'(fc_n) + 32'd7) >> 3);
  assign res_sum   = 32'(alloc_start_q) + 32'(map_bytes) + 32'(bpfa_pkg::PageBytes - 1);
  assign res_raw   = res_sum >> bpfa_pkg::PAGE_SHIFT;
  assign res_n     = (res_raw > bpfa_pkg::MaxFrames) ? count_t'(bpfa_pkg::MaxFrames) :
                                                       count_t'(res_raw);

  // Item decode
  assign req_i.ready = (state_q == S_IDLE);
  assign op_in       = bpfa_pkg::op_e'(req_i.op);
  assign free_frame  = req_i.frame_address[bpfa_pkg::IN_ADDR_W-1:bpfa_pkg::PAGE_SHIFT];
  assign free_fidx   = free_frame[bpfa_pkg::FRAME_W-1:0];
  assign in_range    = free_frame < bpfa_pkg::FADDR_W'(fc_q);
  assign avail       = (fc_q != '0) && !(&top_full_q);
  assign s_sel       = low_zero_top(top_full_q);
  assign w_sel       = low_zero64(sum_rd_q);
  assign b_sel       = low_zero64(word_rd_q);
  assign alloc_word  = word_rd_q | (word_t'(1) << b_sel);
  assign alloc_sum   = sum_rd_q | (word_t'(1) << fidx_q[bpfa_pkg::BIT_W+:bpfa_pkg::BIT_W]);
  assign init_w      = init_word(widx_q, fc_q, res_q);
  assign acc_d       = acc_q | (word_t'(&init_w) << widx_q[bpfa_pkg::BIT_W-1:0]);
  assign can_out     = !rsp_valid_q || rsp_o.ready;

  // Memory port control
  always_comb begin
    word_we    = 1'b0;
    word_re    = 1'b0;
    sum_we     = 1'b0;
    sum_re     = 1'b0;
    word_waddr = fidx_q[bpfa_pkg::FRAME_W-1:bpfa_pkg::BIT_W];
    word_raddr = free_fidx[bpfa_pkg::FRAME_W-1:bpfa_pkg::BIT_W];
    sum_waddr  = fidx_q[bpfa_pkg::FRAME_W-1:bpfa_pkg::FRAME_W-bpfa_pkg::SIDX_W];
    sum_raddr  = free_fidx[bpfa_pkg::FRAME_W-1:bpfa_pkg::FRAME_W-bpfa_pkg::SIDX_W];
    word_wdata = alloc_word;
    sum_wdata  = alloc_sum;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          case (op_in)
            bpfa_pkg::OpAlloc: begin
              sum_re    = avail;
              sum_raddr = s_sel;
            end
            bpfa_pkg::OpFree: begin
              word_re = in_range;
              sum_re  = in_range;
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        word_we    = 1'b1;
        word_waddr = widx_q;
        word_wdata = init_w;
        sum_we     = &widx_q[bpfa_pkg::BIT_W-1:0];
        sum_waddr  = widx_q[bpfa_pkg::WIDX_W-1:bpfa_pkg::BIT_W];
        sum_wdata  = acc_d;
      end
      S_ASUM: begin
        word_re    = 1'b1;
        word_raddr = {fidx_q[bpfa_pkg::FRAME_W-1:bpfa_pkg::FRAME_W-bpfa_pkg::SIDX_W], w_sel};
      end
      S_AWORD: begin
        word_we = 1'b1;
        sum_we  = &alloc_word;
      end
      S_FUPD: begin
        word_we    = 1'b1;
        word_wdata = word_rd_q & ~(word_t'(1) << fidx_q[bpfa_pkg::BIT_W-1:0]);
        sum_we     = 1'b1;
        sum_wdata  = sum_rd_q &
                     ~(word_t'(1) << fidx_q[bpfa_pkg::BIT_W+:bpfa_pkg::BIT_W]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (word_we) word_mem[word_waddr] <= word_wdata;
    if (word_re) word_rd_q <= word_mem[word_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    if (sum_re) sum_rd_q <= sum_mem[sum_raddr];
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      fc_q          <= '0;
      res_q         <= '0;
      cnt_q         <= '0;
      top_full_q    <= '0;
      widx_q        <= '0;
      acc_q         <= '0;
      fidx_q        <= '0;
      pend_addr_q   <= '0;
      pend_status_q <= bpfa_pkg::StOk;
      rsp_valid_q   <= 1'b0;
      rsp_addr_q    <= '0;
      rsp_status_q  <= bpfa_pkg::StOk;
      rsp_total_q   <= '0;
    end else begin
      if (rsp_valid_q && rsp_o.ready && (state_q != S_RESP)) rsp_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            pend_addr_q   <= '0;
            pend_status_q <= bpfa_pkg::StOk;
            state_q       <= S_RESP;
            case (op_in)
              bpfa_pkg::OpInit: begin
                fc_q    <= fc_n;
                res_q   <= res_n;
                cnt_q   <= '0;
                widx_q  <= '0;
                acc_q   <= '0;
                state_q <= S_INIT;
              end
              bpfa_pkg::OpAlloc: begin
                if (avail) begin
                  fidx_q  <= {s_sel, {(bpfa_pkg::FRAME_W - bpfa_pkg::SIDX_W){1'b0}}};
                  state_q <= S_ASUM;
                end else begin
                  pend_status_q <= bpfa_pkg::StOom;
                end
              end
              bpfa_pkg::OpFree: begin
                if (in_range) begin
                  fidx_q  <= free_fidx;
                  state_q <= S_FUPD;
                end else begin
                  pend_status_q <= bpfa_pkg::StRange;
                end
              end
              default: ;
            endcase
          end
        end
        S_INIT: begin
          widx_q <= widx_q + 1'b1;
          if (&widx_q[bpfa_pkg::BIT_W-1:0]) begin
            acc_q <= '0;
            top_full_q[widx_q[bpfa_pkg::WIDX_W-1:bpfa_pkg::BIT_W]] <= &acc_d;
          end else begin
            acc_q <= acc_d;
          end
          if (&widx_q) state_q <= S_RESP;
        end
        S_ASUM: begin
          fidx_q[bpfa_pkg::BIT_W+:bpfa_pkg::BIT_W] <= w_sel;
          state_q <= S_AWORD;
        end
        S_AWORD: begin
          pend_addr_q <= bpfa_pkg::ADDR_W'({fidx_q[bpfa_pkg::FRAME_W-1:bpfa_pkg::BIT_W], b_sel,
                                            {bpfa_pkg::PAGE_SHIFT{1'b0}}});
          if (cnt_q < bpfa_pkg::CountMax) cnt_q <= cnt_q + 1'b1;
          if ((&alloc_word) && (&alloc_sum)) begin
            top_full_q[fidx_q[bpfa_pkg::FRAME_W-1:bpfa_pkg::FRAME_W-bpfa_pkg::SIDX_W]] <= 1'b1;
          end
          state_q <= S_RESP;
        end
        S_FUPD: begin
          top_full_q[fidx_q[bpfa_pkg::FRAME_W-1:bpfa_pkg::FRAME_W-bpfa_pkg::SIDX_W]] <= 1'b0;
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (can_out) begin
            rsp_valid_q  <= 1'b1;
            rsp_addr_q   <= pend_addr_q;
            rsp_status_q <= pend_status_q;
            rsp_total_q  <= cnt_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.result_address = rsp_addr_q;
  assign rsp_o.status         = rsp_status_q;
  assign rsp_o.alloc_total    = rsp_total_q;

  a_sum_has_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ASUM |-> !(&sum_rd_q))
    else $error("summary word picked for alloc has no free word");

  a_word_has_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_AWORD |-> !(&word_rd_q))
    else $error("used-bit word picked for alloc has no free frame");

  a_fail_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (rsp_status_q != bpfa_pkg::StOk) |-> rsp_addr_q == '0)
    else $error("failed item carries a nonzero address");

endmodule

>>> tb/bpfa_alloc_checker.sv
// Scoreboard for the bitmap page frame allocator: shadows the registers, predicts each
// response from the accepted requests and compares field by field.
// Depends on bpfa_pkg, bpfa_req_if and bpfa_rsp_if.
`timescale 1ns / 1ps

module bpfa_alloc_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [bpfa_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [bpfa_pkg::APB_DATA_W-1:0] pwdata,
  input  logic [bpfa_pkg::APB_DATA_W-1:0] prdata,
  bpfa_req_if                             req_i,
  bpfa_rsp_if                             rsp_i,
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o
);
  import bpfa_pkg::*;

  localparam logic [ADDR_W-1:0]     StartAtReset = 28'h010_0000;
  localparam logic [TOP_ADDR_W-1:0] TopAtReset   = 29'h1000_0000;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    status_e            status;
    logic [TOTAL_W-1:0] total;
  } page_result_t;

  page_result_t             pending_results[$];
  logic [ADDR_W-1:0]        start_q;
  logic [TOP_ADDR_W-1:0]    top_q;
  bit                       frame_used[MaxFrames];
  logic [COUNT_W-1:0]       frame_total;
  logic [TOTAL_W-1:0]       alloc_count;
  int unsigned              first_free;
  int unsigned              mismatches = 0;

  function automatic void flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t mismatch: %s", $time, msg);
  endfunction

  // Every frame below first_free is known to be used.
  function automatic void reserve_map();
    longint unsigned frames;
    longint unsigned map_bytes;
    longint unsigned reserved;
    frames = top_q >> PAGE_SHIFT;
    if (frames > MaxFrames) frames = MaxFrames;
    map_bytes = (frames + 7) / 8;
    reserved = (longint'(start_q) + map_bytes + PageBytes - 1) / PageBytes;
    if (reserved > MaxFrames) reserved = MaxFrames;
    frame_total = COUNT_W'(frames);
    alloc_count = '0;
    for (int i = 0; i < MaxFrames; i++) frame_used[i] = (i < reserved);
    first_free = 32'(reserved);
  endfunction

  function automatic void take_lowest_free(inout page_result_t r);
    int unsigned i;
    i = first_free;
    while (i < frame_total && frame_used[i]) i++;
    first_free = i;
    if (i < frame_total) begin
      frame_used[i] = 1'b1;
      first_free = i + 1;
      if (alloc_count < CountMax) alloc_count++;
      r.addr = ADDR_W'(i << PAGE_SHIFT);
    end else begin
      r.status = StOom;
    end
  endfunction

  function automatic void release_frame(input logic [IN_ADDR_W-1:0] byte_addr,
                                        inout page_result_t r);
    logic [FADDR_W-1:0] frame;
    frame = byte_addr[IN_ADDR_W-1:PAGE_SHIFT];
    if (frame < frame_total) begin
      frame_used[frame] = 1'b0;
      if (frame < first_free) first_free = 32'(frame);
    end else begin
      r.status = StRange;
    end
  endfunction

  function automatic page_result_t predict(input logic [OP_W-1:0] op,
                                           input logic [IN_ADDR_W-1:0] byte_addr);
    page_result_t r;
    r.addr   = '0;
    r.status = StOk;
    case (op)
      OpInit:  reserve_map();
      OpAlloc: take_lowest_free(r);
      OpFree:  release_frame(byte_addr, r);
      default: ;
    endcase
    r.total = alloc_count;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    page_result_t              want;
    logic [APB_DATA_W-1:0]     reg_value;
    if (!rst_ni) begin
      start_q     = StartAtReset;
      top_q       = TopAtReset;
      frame_total = '0;
      alloc_count = '0;
      first_free  = 0;
      for (int i = 0; i < MaxFrames; i++) frame_used[i] = 1'b0;
      pending_results.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[APB_ADDR_W-1:2] == REG_ALLOC_START) start_q = pwdata[ADDR_W-1:0];
          else top_q = pwdata[TOP_ADDR_W-1:0];
        end else begin
          reg_value = (paddr[APB_ADDR_W-1:2] == REG_ALLOC_START) ? APB_DATA_W'(start_q) :
                                                                  APB_DATA_W'(top_q);
          if (prdata !== reg_value)
            flag($sformatf("register %0d read %h, want %h", paddr, prdata, reg_value));
        end
      end
      if (req_i.valid && req_i.ready)
        pending_results.push_back(predict(req_i.op, req_i.frame_address));
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_results.size() == 0) begin
          flag($sformatf("item with none outstanding: addr %h status %0d total %0d",
                         rsp_i.result_address, rsp_i.status, rsp_i.alloc_total));
        end else begin
          want = pending_results.pop_front();
          if (rsp_i.result_address !== want.addr || rsp_i.status !== want.status ||
              rsp_i.alloc_total !== want.total)
            flag($sformatf("got addr %h status %0d total %0d, want addr %h status %0d total %0d",
                           rsp_i.result_address, rsp_i.status, rsp_i.alloc_total,
                           want.addr, want.status, want.total));
        end
      end
      pending_o    <= pending_results.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the page frame allocator testbench: clock, reset, register writes, request and
// stall generation, verdict. Depends on bpfa_pkg, the channel interfaces and the checker.
`timescale 1ns / 1ps

module testbench;
  import bpfa_pkg::*;

  localparam logic [OP_W-1:0]       OpUnused    = 2'd3;
  localparam int unsigned           RandomItems = 1550;
  localparam int unsigned           CycleLimit  = 3_000_000;
  localparam logic [TOP_ADDR_W-1:0] TopFull     = 29'h1000_0000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic                  pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  int unsigned           fail_count;
  int unsigned           outstanding;

  bit                    full_speed = 1'b0;
  int unsigned           burst_left = 0;
  int unsigned           cycles = 0;
  int unsigned           n_init = 0;
  int unsigned           n_alloc = 0;
  int unsigned           n_free = 0;
  int unsigned           n_other = 0;
  int unsigned           n_settings = 0;
  logic [ADDR_W-1:0]     cfg_start = 28'h010_0000;
  logic [TOP_ADDR_W-1:0] cfg_top = TopFull;

  bpfa_req_if req_ch ();
  bpfa_rsp_if rsp_ch ();

  bitmap_page_frame_allocator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch)
  );

  bpfa_alloc_checker alloc_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .fail_count_o (fail_count),
    .pending_o    (outstanding)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timed out after %0d cycles, %0d items outstanding", cycles, outstanding);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : rsp_stall
    int unsigned len;
    rsp_ch.ready <= 1'b1;
    forever begin
      len = $urandom_range(1, 24);
      rsp_ch.ready <= 1'b1;
      repeat (len) @(posedge clk_i);
      if (!full_speed && $urandom_range(0, 3) != 0) begin
        len = $urandom_range(1, 7);
        rsp_ch.ready <= 1'b0;
        repeat (len) @(posedge clk_i);
      end
    end
  end

  function automatic logic [IN_ADDR_W-1:0] frame_addr(input longint unsigned frame,
                                                      input logic [PAGE_SHIFT-1:0] offset);
    return IN_ADDR_W'((frame << PAGE_SHIFT) | offset);
  endfunction

  task automatic send(input logic [OP_W-1:0] op, input logic [IN_ADDR_W-1:0] addr);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = (full_speed || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_ch.valid         <= 1'b1;
    req_ch.op            <= op;
    req_ch.frame_address <= addr;
    do @(posedge clk_i); while (!req_ch.ready);
    case (op)
      OpInit:  n_init++;
      OpAlloc: n_alloc++;
      OpFree:  n_free++;
      default: n_other++;
    endcase
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic apb_cycle(input logic wr, input logic idx, input logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [ADDR_W-1:0] new_start,
                           input logic [TOP_ADDR_W-1:0] new_top);
    drain();
    apb_cycle(1'b1, REG_ALLOC_START, APB_DATA_W'(new_start));
    apb_cycle(1'b0, REG_ALLOC_START, '0);
    apb_cycle(1'b1, REG_MEMORY_TOP, APB_DATA_W'(new_top));
    apb_cycle(1'b0, REG_MEMORY_TOP, '0);
    cfg_start = new_start;
    cfg_top   = new_top;
    n_settings++;
  endtask

  initial begin : stimulus
    logic [ADDR_W-1:0]     new_start;
    logic [TOP_ADDR_W-1:0] new_top;
    logic [IN_ADDR_W-1:0]  wild;
    longint unsigned       frame;
    int unsigned           n_random;
    int unsigned           len;
    int unsigned           taken;
    int unsigned           fc_est;
    int unsigned           base;
    int unsigned           k;

    rst_ni               <= 1'b0;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.op            <= OpInit;
    req_ch.frame_address <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // No init yet, then init with the reset register values
    send(OpAlloc, '0);
    send(OpFree, '0);
    send(OpUnused, '1);
    send(OpInit, '0);
    send(OpAlloc, '0);
    send(OpAlloc, '0);
    send(OpFree, frame_addr(259, 12'h7ff));
    send(OpFree, frame_addr(259, 12'h000));
    send(OpAlloc, '0);
    send(OpFree, '1);
    send(OpFree, frame_addr(MaxFrames - 1, 12'hfff));
    send(OpFree, frame_addr(0, 12'h000));
    send(OpAlloc, '0);

    // Three frames: fill, run out, free past the end
    configure('0, TOP_ADDR_W'((3 << PAGE_SHIFT) | 12'hfff));
    send(OpInit, '0);
    send(OpAlloc, '0);
    send(OpAlloc, '0);
    send(OpAlloc, '0);
    send(OpFree, frame_addr(3, 12'h000));
    send(OpFree, frame_addr(1, 12'h123));
    send(OpAlloc, '0);

    // Reserved area covers every frame
    configure('1, TOP_ADDR_W'(8 << PAGE_SHIFT));
    send(OpInit, '0);
    send(OpAlloc, '0);
    send(OpFree, frame_addr(2, 12'h000));
    send(OpAlloc, '0);

    configure('0, '0);
    send(OpInit, '0);
    send(OpAlloc, '0);
    send(OpFree, '0);

    n_random = 0;
    while (n_random < RandomItems) begin
      case ($urandom_range(0, 9))
        0, 1, 2: new_start = ADDR_W'($urandom_range(0, 40000));
        3, 4:    new_start = '0;
        5:       new_start = '1;
        6, 7:    new_start = ADDR_W'($urandom);
        default: new_start = ADDR_W'($urandom_range(0, 64) << PAGE_SHIFT);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4:
          new_top = TOP_ADDR_W'(($urandom_range(0, 48) << PAGE_SHIFT) |
                                $urandom_range(0, PageBytes - 1));
        5:       new_top = '0;
        6:       new_top = TopFull;
        7:       new_top = '1;
        default: new_top = TOP_ADDR_W'($urandom_range(0, TopFull));
      endcase
      configure(new_start, new_top);
      fc_est = cfg_top >> PAGE_SHIFT;
      if (fc_est > MaxFrames) fc_est = MaxFrames;
      base = cfg_start >> PAGE_SHIFT;
      wild = IN_ADDR_W'({$urandom, $urandom});
      send(OpInit, wild);
      n_random++;
      taken = 0;
      len = $urandom_range(20, 90);
      repeat (len) begin
        k = $urandom_range(0, 99);
        wild = IN_ADDR_W'({$urandom, $urandom});
        if (k < 50) begin
          send(OpAlloc, wild);
          taken++;
        end else if (k < 80) begin
          frame = base + $urandom_range(0, taken + 3);
          send(OpFree, frame_addr(frame, PAGE_SHIFT'($urandom_range(0, PageBytes - 1))));
        end else if (k < 86) begin
          frame = $urandom_range(0, 2);
          if (fc_est != 0) frame = frame + fc_est - 1;
          send(OpFree, frame_addr(frame, PAGE_SHIFT'($urandom_range(0, PageBytes - 1))));
        end else if (k < 92) begin
          send(OpFree, wild);
        end else if (k < 96) begin
          send(OpUnused, wild);
          n_random--;
        end else begin
          send(OpInit, wild);
          taken = 0;
        end
        n_random++;
      end
    end

    // Reserve all but the top frames of a full-size map, fill it and run out
    configure(ADDR_W'((MaxFrames - 40) << PAGE_SHIFT), TopFull);
    full_speed = 1'b1;
    send(OpInit, '0);
    repeat (40) send(OpAlloc, '0);
    send(OpFree, frame_addr(MaxFrames - 1, 12'hfff));
    send(OpFree, frame_addr(MaxFrames - 20, 12'h000));
    send(OpAlloc, '0);
    send(OpAlloc, '0);
    send(OpAlloc, '0);
    drain();
    full_speed = 1'b0;

    repeat (16) @(posedge clk_i);
    $display("run covered %0d items: %0d init, %0d alloc, %0d free, %0d unused op",
             n_init + n_alloc + n_free + n_other, n_init, n_alloc, n_free, n_other);
    $display("over %0d register settings, including a full-size map filled to its last frame",
             n_settings);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
